/* design/qbnp_pkg.sv */
// shared constants for the quadtree bounding node path block
`timescale 1ns / 1ps
package qbnp_pkg;

  localparam int MAX_DEPTH     = 24;
  localparam int FRACTION_BITS = 23;

  localparam int COORD_W = 32;
  localparam int NODE_W  = COORD_W + 2;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int PATH_W  = 48;
  localparam int LIMIT_W = 5;

  localparam logic [COORD_W-1:0] SPAN_HALF   = COORD_W'(180 * (2 ** FRACTION_BITS));
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(24);

  localparam int IN_TDATA_W  = 4 * COORD_W;
  localparam int OUT_FIELD_W = PATH_W + LIMIT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // quadrant digits
  localparam logic [1:0] DIGIT_SW = 2'd0;
  localparam logic [1:0] DIGIT_SE = 2'd1;
  localparam logic [1:0] DIGIT_NE = 2'd2;
  localparam logic [1:0] DIGIT_NW = 2'd3;

endpackage

/* design/quadtree_bounding_node_path.sv */
// top level: quadtree descent that finds the smallest node bounding a rectangle
// an accepted beat descends one level at a time until its corners split or the limit is reached,
//   then the result beat is registered in the done state once the output is free
// throughput: one rectangle at a time; the level step unit handles one level per cycle,
//   and a new beat is taken only after the previous result has been registered for output
// reset: rst is synchronous, active high; clears the sequencer and output valid,
//   and sets level_limit to 24
`timescale 1ns / 1ps
module quadtree_bounding_node_path (
  input  logic                                  clk,
  input  logic                                  rst,
  // level limit register
  input  logic                                  level_limit_wen,
  input  logic [qbnp_pkg::LIMIT_W-1:0]          level_limit_wdata,
  // rectangle in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [qbnp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // south_edge, west_edge, north_edge, east_edge
  // node path out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [qbnp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // path_digits, depth_reached, zero pad
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam int CW = qbnp_pkg::COORD_W;
  localparam int NW = qbnp_pkg::NODE_W;
  localparam int DW = qbnp_pkg::DEPTH_W;
  localparam int PW = qbnp_pkg::PATH_W;
  localparam int LW = qbnp_pkg::LIMIT_W;

  state_t state, state_next;

  logic [LW-1:0] level_limit;

  // captured rectangle
  logic signed [CW-1:0] south, west, north, east;

  // descent state: current node corner, half-size, depth, digits so far
  logic signed [NW-1:0] node_south, node_west;
  logic [CW-1:0]        half;
  logic [DW-1:0]        depth;
  logic [DW-1:0]        limit;
  logic [PW-1:0]        digits;

  logic                 in_beat;
  logic                 out_free;

  // level step unit
  logic signed [NW-1:0] mid_ns, mid_ew;
  logic signed [NW-1:0] south_x, west_x, north_x, east_x;
  logic                 sw_low, sw_left, ne_low, ne_left;
  logic [1:0]           sw_digit, ne_digit;
  logic                 at_limit;
  logic                 step_ok;
  logic [DW-1:0]        limit_eff;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // saturate the register to the tree depth
  assign limit_eff = (level_limit > LW'(qbnp_pkg::MAX_DEPTH)) ?
                     DW'(qbnp_pkg::MAX_DEPTH) : DW'(level_limit);

  always_comb begin
    south_x  = NW'(south);
    west_x   = NW'(west);
    north_x  = NW'(north);
    east_x   = NW'(east);
    mid_ns   = node_south + $signed({2'b00, half});
    mid_ew   = node_west  + $signed({2'b00, half});
    sw_low   = (south_x <= mid_ns);
    sw_left  = (west_x  <= mid_ew);
    ne_low   = (north_x <= mid_ns);
    ne_left  = (east_x  <= mid_ew);
    sw_digit = sw_low ? (sw_left ? qbnp_pkg::DIGIT_SW : qbnp_pkg::DIGIT_SE)
                      : (sw_left ? qbnp_pkg::DIGIT_NW : qbnp_pkg::DIGIT_NE);
    ne_digit = ne_low ? (ne_left ? qbnp_pkg::DIGIT_SW : qbnp_pkg::DIGIT_SE)
                      : (ne_left ? qbnp_pkg::DIGIT_NW : qbnp_pkg::DIGIT_NE);
    at_limit = (depth == limit);
    // both corners in the same child and the limit not yet reached: go one level down
    step_ok  = !at_limit && (sw_digit == ne_digit);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!step_ok) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      level_limit   <= qbnp_pkg::LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (level_limit_wen) begin
        level_limit <= level_limit_wdata;
      end
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      south      <= s_axis_tdata[0*CW +: CW];
      west       <= s_axis_tdata[1*CW +: CW];
      north      <= s_axis_tdata[2*CW +: CW];
      east       <= s_axis_tdata[3*CW +: CW];
      node_south <= -$signed({2'b00, qbnp_pkg::SPAN_HALF});
      node_west  <= -$signed({2'b00, qbnp_pkg::SPAN_HALF});
      half       <= qbnp_pkg::SPAN_HALF;
      depth      <= '0;
      limit      <= limit_eff;
      digits     <= '0;
    end else if (state == ST_RUN && step_ok) begin
      if (!ne_left) begin
        node_west <= mid_ew;
      end
      if (!ne_low) begin
        node_south <= mid_ns;
      end
      half                       <= half >> 1;
      digits[{depth, 1'b0} +: 2] <= sw_digit;
      depth                      <= depth + DW'(1);
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= qbnp_pkg::OUT_TDATA_W'({LW'(depth), digits});
    end
  end

endmodule

/* design/qbnp_checker.sv */
// port-level checks for the quadtree bounding node path block
`timescale 1ns / 1ps
module qbnp_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [qbnp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  // result held while stalled
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // busy right after taking a rectangle
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // depth never beyond the tree depth
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      m_axis_tdata[qbnp_pkg::PATH_W +: qbnp_pkg::LIMIT_W] <= qbnp_pkg::LIMIT_W'(qbnp_pkg::MAX_DEPTH))
    else $error("depth beyond tree depth");

  // no result straight out of reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind quadtree_bounding_node_path qbnp_checker u_qbnp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_top.sv */
// testbench for the quadtree bounding node path block: directed and random rectangles
`timescale 1ns / 1ps
module tb_top;
  import qbnp_pkg::*;

  // rectangle as it sits in s_axis_tdata, south edge in the lowest bits
  typedef struct packed {
    logic [COORD_W-1:0] east;
    logic [COORD_W-1:0] north;
    logic [COORD_W-1:0] west;
    logic [COORD_W-1:0] south;
  } rect_t;

  typedef struct packed {
    logic [PATH_W-1:0]  path;
    logic [LIMIT_W-1:0] depth;
  } node_path_t;

  localparam longint SPAN = longint'(SPAN_HALF);

  logic clk = 1'b0;
  logic rst;
  logic level_limit_wen;
  logic [LIMIT_W-1:0] level_limit_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;   // south_edge, west_edge, north_edge, east_edge
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // path_digits, depth_reached, zero pad

  // testbench copy of the level limit register
  logic [LIMIT_W-1:0] level_limit_copy;
  node_path_t pending_nodes[$];
  int mismatches = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  quadtree_bounding_node_path dut (
    .clk               (clk),
    .rst               (rst),
    .level_limit_wen   (level_limit_wen),
    .level_limit_wdata (level_limit_wdata),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // descend from the root while both corners fall in the same child, up to the level limit
  function automatic node_path_t predict_bounding_node(rect_t r, logic [LIMIT_W-1:0] limit);
    longint south, west, north, east;
    longint node_south, node_west, half, mid_ns, mid_ew;
    int lvl, stop_at;
    logic [1:0] sw_quad, ne_quad;
    bit split;
    node_path_t res;
    south = $signed(r.south);
    west = $signed(r.west);
    north = $signed(r.north);
    east = $signed(r.east);
    node_south = -SPAN;
    node_west = -SPAN;
    stop_at = (limit > MAX_DEPTH) ? MAX_DEPTH : int'(limit);
    res = '0;
    lvl = 0;
    split = 1'b0;
    while (lvl < stop_at && !split) begin
      half = SPAN >>> lvl;
      mid_ns = node_south + half;
      mid_ew = node_west + half;
      sw_quad = (south <= mid_ns) ? ((west <= mid_ew) ? DIGIT_SW : DIGIT_SE)
                                  : ((west <= mid_ew) ? DIGIT_NW : DIGIT_NE);
      ne_quad = (north <= mid_ns) ? ((east <= mid_ew) ? DIGIT_SW : DIGIT_SE)
                                  : ((east <= mid_ew) ? DIGIT_NW : DIGIT_NE);
      if (sw_quad != ne_quad) begin
        split = 1'b1;
      end else begin
        if (east > mid_ew) node_west = mid_ew;
        if (north > mid_ns) node_south = mid_ns;
        if (lvl < PATH_W / 2) res.path[2*lvl +: 2] = sw_quad;
        lvl++;
      end
    end
    res.depth = LIMIT_W'(lvl);
    return res;
  endfunction

  function automatic longint clamp_coord(longint c);
    if (c > SPAN) return SPAN;
    if (c < -SPAN) return -SPAN;
    return c;
  endfunction

  function automatic longint rand_coord();
    return longint'($urandom_range(0, 32'd3019898880)) - SPAN;
  endfunction

  // pull a coordinate onto a node boundary or midpoint of some level, off by at most one lsb
  function automatic longint snap_to_grid(longint c);
    longint step;
    int jitter;
    step = SPAN >>> $urandom_range(0, 25);
    jitter = int'($urandom_range(0, 2)) - 1;
    return clamp_coord(-SPAN + ((c + SPAN) / step) * step + jitter);
  endfunction

  function automatic rect_t make_rect(longint s, longint w, longint n, longint e);
    rect_t r;
    r.south = s[COORD_W-1:0];
    r.west = w[COORD_W-1:0];
    r.north = n[COORD_W-1:0];
    r.east = e[COORD_W-1:0];
    return r;
  endfunction

  // mostly small well-formed boxes that reach deep levels, some points, some noise
  function automatic rect_t random_rect();
    longint s, w, n, e, t;
    int kind;
    kind = $urandom_range(0, 99);
    s = rand_coord();
    w = rand_coord();
    if (kind < 10) begin
      n = rand_coord();
      e = rand_coord();
    end else begin
      if (kind < 25) begin
        n = s;
        e = w;
      end else begin
        n = clamp_coord(s + $urandom_range(0, 32'(SPAN >>> $urandom_range(0, 26))));
        e = clamp_coord(w + $urandom_range(0, 32'(SPAN >>> $urandom_range(0, 26))));
      end
      if ($urandom_range(0, 99) < 40) begin
        s = snap_to_grid(s);
        n = snap_to_grid(n);
      end
      if ($urandom_range(0, 99) < 40) begin
        w = snap_to_grid(w);
        e = snap_to_grid(e);
      end
      // inverted edges now and then
      if ($urandom_range(0, 99) < 8) begin
        t = s; s = n; n = t;
      end
      if ($urandom_range(0, 99) < 8) begin
        t = w; w = e; e = t;
      end
    end
    return make_rect(s, w, n, e);
  endfunction

  // one beat in, with an optional idle gap ahead of it; returns at the accepting edge
  task automatic send_rectangle(rect_t r);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= r;
    do @(negedge clk); while (!s_axis_tready);
    pending_nodes.push_back(predict_bounding_node(r, level_limit_copy));
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic set_level_limit(logic [LIMIT_W-1:0] value);
    drain_results();
    level_limit_wen <= 1'b1;
    level_limit_wdata <= value;
    @(posedge clk);
    level_limit_wen <= 1'b0;
    level_limit_copy = value;
  endtask

  // corners of the world, each quadrant, inclusive midpoints, one-lsb splits
  task automatic test_directed_corners();
    send_rectangle(make_rect(-SPAN, -SPAN, SPAN, SPAN));
    send_rectangle(make_rect(0, 0, 0, 0));
    send_rectangle(make_rect(-SPAN, -SPAN, -SPAN, -SPAN));
    send_rectangle(make_rect(SPAN, SPAN, SPAN, SPAN));
    send_rectangle(make_rect(-SPAN, SPAN, -SPAN, SPAN));
    send_rectangle(make_rect(SPAN, -SPAN, SPAN, -SPAN));
    send_rectangle(make_rect(0, 0, 1, 0));
    send_rectangle(make_rect(0, 0, 0, 1));
    send_rectangle(make_rect(-1, -1, 0, 0));
    send_rectangle(make_rect(SPAN, 0, -SPAN, 0));
    send_rectangle(make_rect(0, SPAN, 0, -SPAN));
    send_rectangle(make_rect(-SPAN, -SPAN, 0, 0));
    send_rectangle(make_rect(SPAN / 2 + 1, SPAN / 2 + 1, SPAN, SPAN));
    send_rectangle(make_rect(1234567, -7654321, 1234567, -7654321));
    send_rectangle(make_rect(-1, 1, -1, 1));
  endtask

  // zero limit, shallow, full and saturated limits
  task automatic test_level_limits();
    logic [LIMIT_W-1:0] limits[9] = '{0, 1, 2, 12, 23, 24, 25, 28, 31};
    send_gap_pct = 29;
    recv_stall_pct = 29;
    foreach (limits[i]) begin
      set_level_limit(limits[i]);
      send_rectangle(make_rect(0, 0, 0, 0));
      repeat (19) send_rectangle(random_rect());
    end
  endtask

  task automatic test_random_rectangles(int gap_pct, int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 3))
        0: set_level_limit(LIMIT_W'(24));
        1: set_level_limit(LIMIT_W'(31));
        default: set_level_limit(LIMIT_W'($urandom_range(0, 31)));
      endcase
      repeat (110) send_rectangle(random_rect());
    end
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // handshake signals are stable between edges, so the beat is checked at the falling edge before it is taken
  always @(negedge clk) begin
    node_path_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_nodes.size() == 0) begin
        $display("%0t: unexpected result path=%h depth=%0d", $time,
                 m_axis_tdata[PATH_W-1:0], m_axis_tdata[PATH_W +: LIMIT_W]);
        mismatches++;
      end else begin
        want = pending_nodes.pop_front();
        if (m_axis_tdata[PATH_W-1:0] !== want.path) begin
          $display("%0t: path_digits expected %h actual %h", $time, want.path,
                   m_axis_tdata[PATH_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[PATH_W +: LIMIT_W] !== want.depth) begin
          $display("%0t: depth_reached expected %0d actual %0d", $time, want.depth,
                   m_axis_tdata[PATH_W +: LIMIT_W]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    level_limit_wen = 1'b0;
    level_limit_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    level_limit_copy = LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_corners();
    test_level_limits();
    test_random_rectangles(0, 0);
    test_random_rectangles(50, 0);
    test_random_rectangles(0, 50);
    test_random_rectangles(29, 29);
    drain_results();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
